// ----- hw/rtl/lhr_pkg.sv -----
package lhr_pkg;

   // fixed field widths of the item channels
   localparam int COEFF_W      = 14;
   localparam int HELP_W       = 2;
   localparam int NUM_COEFF_IN = 4;

   // default cell geometry (four coefficients, two help bits, q = 12289)
   localparam int CELL_DIM_DEF  = 4;
   localparam int HELP_BITS_DEF = 2;
   localparam int MODULUS_DEF   = 12289;

   typedef struct packed {
      logic [COEFF_W-1:0] coeff_a;
      logic [COEFF_W-1:0] coeff_b;
      logic [COEFF_W-1:0] coeff_c;
      logic [COEFF_W-1:0] coeff_d;
      logic               nudge_bit;
   } req_type;

   typedef struct packed {
      logic [HELP_W-1:0] help_a;
      logic [HELP_W-1:0] help_b;
      logic [HELP_W-1:0] help_c;
      logic [HELP_W-1:0] help_d;
      logic              key_bit;
   } rsp_type;

endpackage

// ----- hw/rtl/lattice_help_reconcile.sv -----
// an accepted item passes the input, middle and result register, in that order, before result valid
// throughput: one cell per cycle; the pipeline only holds while the result side stalls
// the two multiplier stages (reciprocal divide by q, then v0 * 2q) each end in a register
// reset: synchronous, active high; clears the three stage valid bits, payload is not reset
module lattice_help_reconcile #(
   parameter int CELL_DIM  = lhr_pkg::CELL_DIM_DEF,
   parameter int HELP_BITS = lhr_pkg::HELP_BITS_DEF,
   parameter int MODULUS   = lhr_pkg::MODULUS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  lhr_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output lhr_pkg::rsp_type rsp_data
);
   import lhr_pkg::*;

   // scaled coefficient: (2c + nudge) << HELP_BITS
   localparam int XW    = COEFF_W + 1 + HELP_BITS;
   localparam int QW    = $clog2(MODULUS + 1);
   localparam int LOGQ  = $clog2(MODULUS);
   // exact reciprocal divide: floor(x / q) = (x * ceil(2^(XW+LOGQ) / q)) >> (XW+LOGQ)
   localparam int SHIFT = XW + LOGQ;
   localparam int RW    = XW + 1;
   localparam int PW    = SHIFT + XW;
   localparam logic [63:0] RECIP =
      ((64'd1 << SHIFT) + 64'(MODULUS) - 64'd1) / 64'(MODULUS);
   localparam logic [RW-1:0] RECIP_W = RECIP[RW-1:0];
   // distance and sum widths
   localparam int MW    = ((XW > QW) ? XW : QW) + 1;
   localparam int SW    = MW + $clog2(CELL_DIM);
   localparam int M0W   = XW + QW + 1;
   localparam logic [QW:0] TWO_Q = (QW + 1)'(2 * MODULUS);
   localparam int THRESH = (CELL_DIM * MODULUS + 1) / 2;

   // ---------------------------------------------------------------
   // pipeline control: each stage moves when the next one is free
   // ---------------------------------------------------------------
   logic s0_valid_ff, s0_valid_in;
   logic s1_valid_ff, s1_valid_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic out_move, s1_move, s0_move;

   assign out_move  = !rsp_valid_ff || !rsp_stall;
   assign s1_move   = !s1_valid_ff || out_move;
   assign s0_move   = !s0_valid_ff || s1_move;
   assign req_stall = !s0_move;

   assign s0_valid_in  = s0_move  ? req_valid   : s0_valid_ff;
   assign s1_valid_in  = s1_move  ? s0_valid_ff : s1_valid_ff;
   assign rsp_valid_in = out_move ? s1_valid_ff : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff  <= 1'b0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s0_valid_ff  <= s0_valid_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   // ---------------------------------------------------------------
   // input register
   // ---------------------------------------------------------------
   req_type s0_data_ff;

   always_ff @(posedge clock) begin
      if (s0_move) begin
         s0_data_ff <= req_data;
      end
   end

   // ---------------------------------------------------------------
   // stage 1: scale each coefficient, divide by q, find v0 and the odd index
   // ---------------------------------------------------------------
   logic [COEFF_W-1:0]   coeff_in [NUM_COEFF_IN];
   logic [COEFF_W-1:0]   coeff    [CELL_DIM];
   logic [XW-1:0]        xx       [CELL_DIM];
   logic [PW-1:0]        prod     [CELL_DIM];
   logic [XW-1:0]        quo      [CELL_DIM];
   logic [XW:0]          quo_inc  [CELL_DIM];
   logic [XW-1:0]        v0       [CELL_DIM];
   logic [HELP_BITS-1:0] p1       [CELL_DIM];

   logic [XW-1:0]        xx_ff    [CELL_DIM];
   logic [XW-1:0]        v0_ff    [CELL_DIM];
   logic [HELP_BITS-1:0] p1_ff    [CELL_DIM];

   assign coeff_in[0] = s0_data_ff.coeff_a;
   assign coeff_in[1] = s0_data_ff.coeff_b;
   assign coeff_in[2] = s0_data_ff.coeff_c;
   assign coeff_in[3] = s0_data_ff.coeff_d;

   for (genvar j = 0; j < CELL_DIM; j++) begin : g_front
      // coefficients past the input fields are zero
      if (j < NUM_COEFF_IN) begin : g_used
         assign coeff[j] = coeff_in[j];
      end else begin : g_zero
         assign coeff[j] = '0;
      end

      assign xx[j]      = {coeff[j], s0_data_ff.nudge_bit, {HELP_BITS{1'b0}}};
      assign prod[j]    = PW'(xx[j]) * PW'(RECIP_W);
      assign quo[j]     = prod[j][SHIFT +: XW];
      // v0: nearest even multiple of q, index rounded up
      assign quo_inc[j] = {1'b0, quo[j]} + (XW + 1)'(1);
      assign v0[j]      = quo_inc[j][XW:1];
      // odd offset point index
      assign p1[j]      = quo[j][HELP_BITS:1];

      always_ff @(posedge clock) begin
         if (s1_move) begin
            xx_ff[j] <= xx[j];
            v0_ff[j] <= v0[j];
            p1_ff[j] <= p1[j];
         end
      end
   end

   // ---------------------------------------------------------------
   // stage 2: distance to v0 points, pick even or odd lattice, build help data
   // ---------------------------------------------------------------
   logic [M0W-1:0]       m0_full [CELL_DIM];
   logic [MW-1:0]        m0      [CELL_DIM];
   logic [MW-1:0]        xx_ext  [CELL_DIM];
   logic [MW-1:0]        dev     [CELL_DIM];
   logic [SW-1:0]        dist_sum;
   logic                 choose_odd;
   logic [HELP_BITS-1:0] point   [CELL_DIM];
   logic [HELP_BITS-1:0] last_idx;
   logic [HELP_BITS:0]   last_sh;
   logic [HELP_BITS-1:0] sub     [CELL_DIM];
   logic [HELP_W-1:0]    help_sub [3];
   rsp_type              rsp_next;
   rsp_type              rsp_data_ff;

   function automatic logic [HELP_W-1:0] fit_help(input logic [HELP_BITS-1:0] v);
      logic [HELP_BITS+HELP_W-1:0] w;
      w = {{HELP_W{1'b0}}, v};
      return w[HELP_W-1:0];
   endfunction

   for (genvar j = 0; j < CELL_DIM; j++) begin : g_dist
      assign m0_full[j] = M0W'(v0_ff[j]) * M0W'(TWO_Q);
      assign m0[j]      = m0_full[j][MW-1:0];
      assign xx_ext[j]  = MW'(xx_ff[j]);
      assign dev[j]     = (xx_ext[j] > m0[j]) ? (xx_ext[j] - m0[j]) : (m0[j] - xx_ext[j]);
   end

   always_comb begin
      dist_sum = '0;
      for (int j = 0; j < CELL_DIM; j++) begin
         dist_sum = dist_sum + SW'(dev[j]);
      end
   end

   // below half of CELL_DIM * q keeps the even lattice
   assign choose_odd = !(dist_sum < SW'(THRESH));

   for (genvar j = 0; j < CELL_DIM; j++) begin : g_point
      assign point[j] = choose_odd ? p1_ff[j] : v0_ff[j][HELP_BITS-1:0];
   end

   assign last_idx = point[CELL_DIM-1];
   assign last_sh  = {last_idx, choose_odd};

   for (genvar j = 0; j < CELL_DIM; j++) begin : g_sub
      if (j < CELL_DIM - 1) begin : g_rel
         // relative to the last subcell, wraps mod 2^HELP_BITS
         assign sub[j] = point[j] - last_idx;
      end else begin : g_last
         assign sub[j] = last_sh[HELP_BITS-1:0];
      end
   end

   for (genvar k = 0; k < 3; k++) begin : g_help
      if (k < CELL_DIM - 1) begin : g_have
         assign help_sub[k] = fit_help(sub[k]);
      end else begin : g_none
         assign help_sub[k] = '0;
      end
   end

   always_comb begin
      rsp_next.help_a  = help_sub[0];
      rsp_next.help_b  = help_sub[1];
      rsp_next.help_c  = help_sub[2];
      rsp_next.help_d  = fit_help(sub[CELL_DIM-1]);
      rsp_next.key_bit = last_idx[HELP_BITS-1];
   end

   // ---------------------------------------------------------------
   // result register
   // ---------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (out_move) begin
         rsp_data_ff <= rsp_next;
      end
   end

   assign rsp_data = rsp_data_ff;

`ifndef SYNTHESIS
   // a full middle stage behind a stalled result must stay put
   a_mid_hold: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && rsp_valid_ff && rsp_stall |=> s1_valid_ff && rsp_valid_ff)
      else $error("middle stage lost an item under result stall");

   // a taken result with nothing behind it empties the output register
   a_out_drain: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_stall && !s1_valid_ff |=> !rsp_valid_ff)
      else $error("result repeated after being taken");

   // input must be held off when every stage is full and the output stalls
   a_full_stall: assert property (@(posedge clock) disable iff (reset)
      s0_valid_ff && s1_valid_ff && rsp_valid_ff && rsp_stall |-> req_stall)
      else $error("item accepted into a full pipeline");
`endif

endmodule
